/* hw/rtl/sncu_pkg.sv */
// Shared types, constants and hash helpers for the nonce difficulty check unit.
package sncu_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED_VALUE      = 8'd0,
    CFG_DIFFICULTY_BITS = 8'd1
  } cfg_idx_e;

  localparam logic [47:0] MSG_HEAD = 48'h626c6f636b5f;      // "block_"
  localparam logic [55:0] MSG_MID  = 56'h5f6e6f6e63655f;    // "_nonce_"

  typedef struct packed {
    logic [79:0] bcd;
    logic [63:0] bin;
  } dd_t;

  typedef logic [7:0][31:0]  sha_state_t;   // [0] = a ... [7] = h
  typedef logic [15:0][31:0] sha_win_t;     // [0] = oldest schedule word

  typedef struct packed {
    logic        meets_target;
    logic [8:0]  leading_zero_bits;
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
  } result_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic sha_state_t init_state();
    sha_state_t s;
    for (int i = 0; i < 8; i++) begin
      s[i] = SHA_H[i];
    end
    return s;
  endfunction

  // One double-dabble step: add-3 correction per digit, then shift one bit in.
  function automatic dd_t dd_step(dd_t x);
    dd_t y;
    y = x;
    for (int i = 0; i < 20; i++) begin
      if (y.bcd[4*i +: 4] >= 4'd5) begin
        y.bcd[4*i +: 4] = y.bcd[4*i +: 4] + 4'd3;
      end
    end
    y.bcd = {y.bcd[78:0], y.bin[63]};
    y.bin = {y.bin[62:0], 1'b0};
    return y;
  endfunction

  function automatic dd_t dd_step4(dd_t x);
    return dd_step(dd_step(dd_step(dd_step(x))));
  endfunction

  // Number of significant decimal digits, at least one.
  function automatic logic [4:0] digit_count(logic [79:0] bcd);
    logic [4:0] n;
    n = 5'd1;
    for (int i = 0; i < 20; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        n = 5'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic sha_state_t sha_round(sha_state_t s, logic [31:0] k, logic [31:0] w);
    sha_state_t o;
    logic [31:0] s1, ch, t1, s0, mj, t2;
    s1 = rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25);
    ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
    t1 = s[7] + s1 + ch + k + w;
    s0 = rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22);
    mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
    t2 = s0 + mj;
    o[7] = s[6];
    o[6] = s[5];
    o[5] = s[4];
    o[4] = s[3] + t1;
    o[3] = s[2];
    o[2] = s[1];
    o[1] = s[0];
    o[0] = t1 + t2;
    return o;
  endfunction

  function automatic sha_win_t sched_next(sha_win_t w);
    sha_win_t o;
    logic [31:0] s0, s1;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    o[14:0] = w[15:1];
    o[15] = w[0] + s0 + w[9] + s1;
    return o;
  endfunction

  function automatic logic [6:0] lz64(logic [63:0] w);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        n = 7'(63 - i);
      end
    end
    return n;
  endfunction

endpackage

/* hw/rtl/sncu_if.sv */
// Handshake channel interfaces: nonce input, result output, register writes.
interface sncu_item_if;
  logic        valid;
  logic        ready;
  logic [63:0] nonce;
  modport source (output valid, output nonce, input ready);
  modport sink (input valid, input nonce, output ready);
endinterface

interface sncu_result_if;
  logic             valid;
  logic             ready;
  sncu_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sncu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sncu_pkg::CFG_IDX_W-1:0] index;
  logic [63:0]                    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sha256_nonce_difficulty_check_unit.sv */
// Top level: pipelined SHA-256 proof-of-work check of one nonce per cycle while item_i.ready is high.
//
//  channel   | dir | payload                                   | transfer when
//  ----------+-----+-------------------------------------------+-------------------
//  item_i    | in  | nonce[63:0]                               | valid & ready
//  result_o  | out | meets_target, leading_zero_bits, digest   | valid & ready
//  cfg_i     | in  | index (0 seed, 1 difficulty), data[63:0]  | valid & ready (=1)
//
// One nonce per cycle while the skid register is empty.
// The depth is set by the 64 unrolled round stages plus 16 decimal stages,
// with one stage each for digit count, assembly, feed-forward add and zero count.
// Reset clears valid bits and configuration registers; payload flops are not reset.
// A full output register plus a skid register hold results under stall;
// item_i.ready drops only while the skid register is occupied.
module sha256_nonce_difficulty_check_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  sncu_item_if.sink      item_i,
  sncu_result_if.source  result_o,
  sncu_cfg_if.sink       cfg_i
);

  localparam int unsigned NDD   = 16;   // decimal conversion stages, 4 bits each
  localparam int unsigned NRND  = 64;
  localparam int unsigned NSTG  = NDD + 2 + NRND + 2;

  // configuration registers
  logic [63:0] seed_q;
  logic [8:0]  diff_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      diff_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sncu_pkg::CFG_SEED_VALUE:      seed_q <= cfg_i.data;
        sncu_pkg::CFG_DIFFICULTY_BITS: diff_q <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances as one; it stops only while the skid register is full.
  logic            en;
  logic [NSTG-1:0] v_q;
  logic            skid_v_q;
  logic            out_v_q;

  assign en           = ~skid_v_q;
  assign item_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], item_i.valid};
    end
  end

  // Decimal conversion of nonce and seed (double dabble, 4 steps per stage)
  sncu_pkg::dd_t nz_q [NDD];
  sncu_pkg::dd_t sd_q [NDD];

  for (genvar j = 0; j < NDD; j++) begin : g_dd
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          nz_q[j] <= sncu_pkg::dd_step4('{bcd: '0, bin: item_i.nonce});
          sd_q[j] <= sncu_pkg::dd_step4('{bcd: '0, bin: seed_q});
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en) begin
          nz_q[j] <= sncu_pkg::dd_step4(nz_q[j-1]);
          sd_q[j] <= sncu_pkg::dd_step4(sd_q[j-1]);
        end
      end
    end
  end

  // Digit counts
  logic [79:0] bn_q, bs_q;
  logic [4:0]  ln_q, ls_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bn_q <= nz_q[NDD-1].bcd;
      bs_q <= sd_q[NDD-1].bcd;
      ln_q <= sncu_pkg::digit_count(nz_q[NDD-1].bcd);
      ls_q <= sncu_pkg::digit_count(sd_q[NDD-1].bcd);
    end
  end

  // Message assembly: head, seed digits, then the tail ("_nonce_", digits, 0x80)
  // shifted right to land just after the seed; bit length in the last 8 bytes.
  logic [79:0]  sa, na;
  logic [159:0] sasc, nasc;
  logic [223:0] tail;
  logic [447:0] body;
  logic [5:0]   mlen;
  logic [511:0] msg_d, msg_q;

  always_comb begin
    sa = bs_q << {(5'd20 - ls_q), 2'b00};
    na = bn_q << {(5'd20 - ln_q), 2'b00};
    for (int i = 0; i < 20; i++) begin
      sasc[159-8*i -: 8] = (5'(i) < ls_q) ? {4'h3, sa[79-4*i -: 4]} : 8'h00;
      nasc[159-8*i -: 8] = (5'(i) < ln_q) ? {4'h3, na[79-4*i -: 4]} : 8'h00;
    end
    tail  = {sncu_pkg::MSG_MID, nasc, 8'h00} | (224'h80 << {(5'd20 - ln_q), 3'b000});
    body  = {sncu_pkg::MSG_HEAD, sasc, 240'd0}
          | ({tail, 224'd0} >> {(6'd6 + {1'b0, ls_q}), 3'b000});
    mlen  = 6'd13 + {1'b0, ls_q} + {1'b0, ln_q};
    msg_d = {body, 55'd0, mlen, 3'b000};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msg_q <= msg_d;
    end
  end

  // Compression rounds, one per stage, with the schedule window alongside
  sncu_pkg::sha_win_t   win0;
  sncu_pkg::sha_state_t st_q  [NRND];
  sncu_pkg::sha_win_t   win_q [NRND];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win0[i] = msg_q[511-32*i -: 32];
    end
  end

  for (genvar r = 0; r < NRND; r++) begin : g_rnd
    if (r == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          st_q[r]  <= sncu_pkg::sha_round(sncu_pkg::init_state(), sncu_pkg::SHA_K[r], win0[0]);
          win_q[r] <= sncu_pkg::sched_next(win0);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en) begin
          st_q[r]  <= sncu_pkg::sha_round(st_q[r-1], sncu_pkg::SHA_K[r], win_q[r-1][0]);
          win_q[r] <= sncu_pkg::sched_next(win_q[r-1]);
        end
      end
    end
  end

  // Final feed-forward add
  logic [255:0] dig_q, dig2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 8; i++) begin
        dig_q[255-32*i -: 32] <= st_q[NRND-1][i] + sncu_pkg::SHA_H[i];
      end
    end
  end

  // Leading zero count per 64-bit word
  logic [3:0][6:0] lzw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dig2_q <= dig_q;
      for (int i = 0; i < 4; i++) begin
        lzw_q[i] <= sncu_pkg::lz64(dig_q[255-64*i -: 64]);
      end
    end
  end

  // Combine counts and compare against the difficulty
  sncu_pkg::result_t res_d, out_q, skid_q;
  logic [8:0]        lz_tot;

  always_comb begin
    if (!lzw_q[0][6]) begin
      lz_tot = {2'b00, lzw_q[0]};
    end else if (!lzw_q[1][6]) begin
      lz_tot = 9'd64 + {2'b00, lzw_q[1]};
    end else if (!lzw_q[2][6]) begin
      lz_tot = 9'd128 + {2'b00, lzw_q[2]};
    end else begin
      lz_tot = 9'd192 + {2'b00, lzw_q[3]};
    end
    res_d.meets_target      = (lz_tot >= diff_q);
    res_d.leading_zero_bits = lz_tot;
    res_d.digest_word_0     = dig2_q[255:192];
    res_d.digest_word_1     = dig2_q[191:128];
    res_d.digest_word_2     = dig2_q[127:64];
    res_d.digest_word_3     = dig2_q[63:0];
  end

  // Output register with skid
  logic pv;
  assign pv = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (en) begin
      if (pv) begin
        if (!out_v_q || result_o.ready) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end else if (result_o.ready) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pv) begin
        if (!out_v_q || result_o.ready) begin
          out_q <= res_d;
        end else begin
          skid_q <= res_d;
        end
      end
    end else if (result_o.ready) begin
      out_q <= skid_q;
    end
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

endmodule

/* hw/rtl/sncu_checker.sv */
// Port-level checker for the nonce difficulty check unit, with its bind.
module sncu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        item_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        meets_i,
  input logic [8:0]  lz_i,
  input logic [63:0] word0_i
);

  a_lz_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> lz_i <= 9'd256)
    else $error("leading zero count out of range");

  a_lz_word0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && word0_i != 64'd0) |-> lz_i < 9'd64)
    else $error("leading zero count disagrees with top digest word");

  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_ready_i |-> res_valid_i)
    else $error("input stalled with no result pending");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i && $stable(lz_i) && $stable(meets_i))
    else $error("stalled result changed");

endmodule

bind sha256_nonce_difficulty_check_unit sncu_checker u_sncu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_ready_i (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .meets_i      (result_o.data.meets_target),
  .lz_i         (result_o.data.leading_zero_bits),
  .word0_i      (result_o.data.digest_word_0)
);
